>>> rtl/core/lmpf_pkg.sv
package lmpf_pkg;

	localparam int LOG2_EXT_AX0_DEF = 4;
	localparam int LOG2_EXT_AX1_DEF = 4;
	localparam int LOG2_EXT_AX2_DEF = 4;
	localparam int LOG2_EXT_AX3_DEF = 5;
	localparam int PHASE_BITS_DEF   = 12;

	localparam int NUM_AXES   = 4;
	localparam int NUM_MOM    = 3;
	localparam int SITE_W     = 8;
	localparam int MOM_W      = 8;
	localparam int ORIGIN_W   = 9;
	localparam int OUT_W      = 16;
	localparam int TAB_W      = 15;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam logic [15:0]     THIRD_Q16   = 16'd21846;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_AXIS  = 3'd0,
		REG_DEGEN_MODE = 3'd1,
		REG_ORIGIN_AX0 = 3'd2,
		REG_ORIGIN_AX1 = 3'd3,
		REG_ORIGIN_AX2 = 3'd4,
		REG_ORIGIN_AX3 = 3'd5
	} cfg_reg_t;

	// sin(pi/2 * r / 2^(pb-2)) in Q15, Taylor series through x^15 in Q30
	function automatic logic [TAB_W-1:0] quarter_entry(input int unsigned r,
			input int unsigned pb);
		longint unsigned theta;
		longint unsigned t2;
		longint unsigned term;
		longint          sum;
		theta = (HALF_PI_Q30 * 64'(r)) >> (pb - 2);
		t2    = (theta * theta) >> 30;
		term  = theta;
		sum   = longint'(theta);
		term  = ((term * t2) >> 30) / 6;
		sum   = sum - longint'(term);
		term  = ((term * t2) >> 30) / 20;
		sum   = sum + longint'(term);
		term  = ((term * t2) >> 30) / 42;
		sum   = sum - longint'(term);
		term  = ((term * t2) >> 30) / 72;
		sum   = sum + longint'(term);
		term  = ((term * t2) >> 30) / 110;
		sum   = sum - longint'(term);
		term  = ((term * t2) >> 30) / 156;
		sum   = sum + longint'(term);
		term  = ((term * t2) >> 30) / 210;
		sum   = sum - longint'(term);
		if (sum < 0) begin
			return '0;
		end
		sum = (sum + 16384) >>> 15;
		if (sum > 32767) begin
			sum = 32767;
		end
		return TAB_W'(sum);
	endfunction

endpackage

>>> rtl/core/lmpf_qrom.sv
module lmpf_qrom #(
	parameter int PHASE_BITS = lmpf_pkg::PHASE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [PHASE_BITS-2:0]       sin_addr,
	input  logic [PHASE_BITS-2:0]       cos_addr,
	output logic [lmpf_pkg::TAB_W-1:0]  sin_mag,
	output logic [lmpf_pkg::TAB_W-1:0]  cos_mag
);
	import lmpf_pkg::*;

	localparam int QSIZE = 1 << (PHASE_BITS - 2);

	logic [TAB_W-1:0] qtab [QSIZE+1];

	initial begin
		for (int r = 0; r <= QSIZE; r++) begin
			qtab[r] = quarter_entry(r, PHASE_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag <= qtab[sin_addr];
			cos_mag <= qtab[cos_addr];
		end
	end

endmodule

>>> rtl/core/lattice_momentum_phase_factor.sv
// Plane-wave phase generator: one beat in, one beat out, one item per clock unless
// stalled, through five register stages (input register, phase sum, quarter-wave table
// read, sum of the three permutations, optional divide-by-three and saturate). The table
// read port sets the pipeline depth; each of the three permutation lanes has its own
// table of 2^(PHASE_BITS-2)+1 entries with a sine and a cosine read port. Stages are
// individually stalled, so bubbles collapse and input is taken while a result waits.
// Write configuration only while the pipeline is empty; the block does not enforce it.
module lattice_momentum_phase_factor #(
	parameter int LOG2_EXT_AX0 = lmpf_pkg::LOG2_EXT_AX0_DEF,
	parameter int LOG2_EXT_AX1 = lmpf_pkg::LOG2_EXT_AX1_DEF,
	parameter int LOG2_EXT_AX2 = lmpf_pkg::LOG2_EXT_AX2_DEF,
	parameter int LOG2_EXT_AX3 = lmpf_pkg::LOG2_EXT_AX3_DEF,
	parameter int PHASE_BITS   = lmpf_pkg::PHASE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lmpf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lmpf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// site_ax0, site_ax1, site_ax2, site_ax3, mom_first, mom_second, mom_third
	input  logic [lmpf_pkg::IN_DATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// phase_re, phase_im
	output logic [lmpf_pkg::OUT_DATA_W-1:0]    m_tdata
);
	import lmpf_pkg::*;

	localparam int AW    = PHASE_BITS - 1;
	localparam int RW    = PHASE_BITS - 2;
	localparam int QSIZE = 1 << RW;
	localparam int SHW   = $clog2(PHASE_BITS);
	localparam int EXT_LOG2 [NUM_AXES] = '{LOG2_EXT_AX0, LOG2_EXT_AX1,
		LOG2_EXT_AX2, LOG2_EXT_AX3};
	// momentum slot paired with axis slot a in permutation k
	localparam int MSLOT [NUM_MOM][NUM_MOM] = '{'{0, 1, 2}, '{1, 2, 0}, '{2, 0, 1}};

	typedef struct packed {
		logic          neg;
		logic [AW-1:0] addr;
	} tab_ref_t;

	function automatic tab_ref_t fold(input logic [PHASE_BITS-1:0] p);
		tab_ref_t t;
		logic [RW-1:0] r;
		r = p[RW-1:0];
		t.neg  = p[PHASE_BITS-1];
		t.addr = p[PHASE_BITS-2] ? AW'(QSIZE) - AW'(r) : AW'(r);
		return t;
	endfunction

	function automatic logic signed [OUT_W-1:0] third(input logic [16:0] mag,
			input logic neg);
		logic [31:0]      acc;
		logic [TAB_W-1:0] q;
		acc = 32'(mag) * 32'(THIRD_Q16) + 32'd32768;
		q   = (acc[31:16] > 16'd32767) ? TAB_W'(32767) : acc[TAB_W+15:16];
		return neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
	endfunction

	// configuration
	logic [1:0]                 prop_axis_q;
	logic                       degen_q;
	logic signed [ORIGIN_W-1:0] origin_q [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_axis_q <= 2'd3;
			degen_q     <= 1'b0;
			for (int a = 0; a < NUM_AXES; a++) begin
				origin_q[a] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_AXIS:  prop_axis_q <= cfg_data[1:0];
				REG_DEGEN_MODE: degen_q     <= cfg_data[0];
				REG_ORIGIN_AX0: origin_q[0] <= $signed(cfg_data);
				REG_ORIGIN_AX1: origin_q[1] <= $signed(cfg_data);
				REG_ORIGIN_AX2: origin_q[2] <= $signed(cfg_data);
				REG_ORIGIN_AX3: origin_q[3] <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// stage control
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	assign en5      = !v_s5 || m_tready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign s_tready = en1;
	assign m_tvalid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= s_tvalid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	// stage 1: input beat
	logic [SITE_W-1:0] site_s1 [NUM_AXES];
	logic [MOM_W-1:0]  mom_s1  [NUM_MOM];

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				site_s1[a] <= s_tdata[a*SITE_W +: SITE_W];
			end
			for (int m = 0; m < NUM_MOM; m++) begin
				mom_s1[m] <= s_tdata[NUM_AXES*SITE_W + m*MOM_W +: MOM_W];
			end
		end
	end

	// phase sums; only the low byte of each product can reach the turn counter
	logic [PHASE_BITS-1:0] phase_d [NUM_MOM];

	always_comb begin
		logic [9:0]            x_full;
		logic [SITE_W-1:0]     x8   [NUM_AXES];
		logic [1:0]            ax   [NUM_MOM];
		logic [SHW-1:0]        sh   [NUM_MOM];
		logic [15:0]           prod;
		logic [PHASE_BITS+7:0] term;
		for (int a = 0; a < NUM_AXES; a++) begin
			x_full = $signed({2'b00, site_s1[a]}) + 10'(origin_q[a]);
			x8[a]  = x_full[SITE_W-1:0];
		end
		for (int m = 0; m < NUM_MOM; m++) begin
			ax[m] = prop_axis_q + 2'(m + 1);
			sh[m] = SHW'(PHASE_BITS - EXT_LOG2[ax[m]]);
		end
		for (int k = 0; k < NUM_MOM; k++) begin
			phase_d[k] = '0;
			for (int a = 0; a < NUM_MOM; a++) begin
				prod = x8[ax[a]] * mom_s1[MSLOT[k][a]];
				term = (PHASE_BITS+8)'(prod[7:0]) << sh[MSLOT[k][a]];
				phase_d[k] = phase_d[k] + term[PHASE_BITS-1:0];
			end
		end
	end

	// stage 2: phases
	logic [PHASE_BITS-1:0] phase_s2 [NUM_MOM];
	logic                  degen_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			phase_s2 <= phase_d;
			degen_s2 <= degen_q;
		end
	end

	// stage 3: table reads
	logic [TAB_W-1:0] sin_mag_s3 [NUM_MOM];
	logic [TAB_W-1:0] cos_mag_s3 [NUM_MOM];
	logic             sin_neg_s3 [NUM_MOM];
	logic             cos_neg_s3 [NUM_MOM];
	logic             degen_s3;

	for (genvar k = 0; k < NUM_MOM; k++) begin : g_lane
		tab_ref_t sin_ref;
		tab_ref_t cos_ref;

		assign sin_ref = fold(phase_s2[k]);
		assign cos_ref = fold(phase_s2[k] + PHASE_BITS'(QSIZE));

		lmpf_qrom #(
			.PHASE_BITS(PHASE_BITS)
		) u_qrom (
			.clk     (clk),
			.en      (en3),
			.sin_addr(sin_ref.addr),
			.cos_addr(cos_ref.addr),
			.sin_mag (sin_mag_s3[k]),
			.cos_mag (cos_mag_s3[k])
		);

		always_ff @(posedge clk) begin
			if (en3) begin
				sin_neg_s3[k] <= sin_ref.neg;
				cos_neg_s3[k] <= cos_ref.neg;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3) degen_s3 <= degen_s2;
	end

	// permutation sums
	logic signed [OUT_W-1:0] re0_d, im0_d;
	logic [16:0]             mag_re_d, mag_im_d;
	logic                    neg_re_d, neg_im_d;

	always_comb begin
		logic signed [17:0] sv [NUM_MOM];
		logic signed [17:0] cv [NUM_MOM];
		logic signed [17:0] sum_sin, sum_cos;
		for (int k = 0; k < NUM_MOM; k++) begin
			sv[k] = sin_neg_s3[k] ? -$signed({3'b000, sin_mag_s3[k]})
				: $signed({3'b000, sin_mag_s3[k]});
			cv[k] = cos_neg_s3[k] ? -$signed({3'b000, cos_mag_s3[k]})
				: $signed({3'b000, cos_mag_s3[k]});
		end
		sum_sin  = sv[0] + sv[1] + sv[2];
		sum_cos  = cv[0] + cv[1] + cv[2];
		re0_d    = cv[0][OUT_W-1:0];
		im0_d    = -sv[0][OUT_W-1:0];
		neg_re_d = sum_cos[17];
		neg_im_d = !sum_sin[17] && (sum_sin != '0);
		mag_re_d = sum_cos[17] ? 17'(-sum_cos) : sum_cos[16:0];
		mag_im_d = sum_sin[17] ? 17'(-sum_sin) : sum_sin[16:0];
	end

	// stage 4
	logic signed [OUT_W-1:0] re0_s4, im0_s4;
	logic [16:0]             mag_re_s4, mag_im_s4;
	logic                    neg_re_s4, neg_im_s4;
	logic                    degen_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			re0_s4    <= re0_d;
			im0_s4    <= im0_d;
			mag_re_s4 <= mag_re_d;
			mag_im_s4 <= mag_im_d;
			neg_re_s4 <= neg_re_d;
			neg_im_s4 <= neg_im_d;
			degen_s4  <= degen_s3;
		end
	end

	// stage 5: output beat
	logic signed [OUT_W-1:0] re_s5, im_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			re_s5 <= degen_s4 ? third(mag_re_s4, neg_re_s4) : re0_s4;
			im_s5 <= degen_s4 ? third(mag_im_s4, neg_im_s4) : im0_s4;
		end
	end

	assign m_tdata = {im_s5, re_s5};

endmodule

>>> tb/tb_lattice_momentum_phase_factor.sv
`timescale 1ns / 1ps

module tb_lattice_momentum_phase_factor;
	import lmpf_pkg::*;

	localparam int PB          = PHASE_BITS_DEF;
	localparam int QSIZE       = 1 << (PB - 2);
	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_PHASES  = 8;
	localparam int PHASE_ITEMS = 62;

	// indexes past the register list; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 3'd7;

	typedef struct packed {
		logic [MOM_W-1:0]  mom_third;
		logic [MOM_W-1:0]  mom_second;
		logic [MOM_W-1:0]  mom_first;
		logic [SITE_W-1:0] site_ax3;
		logic [SITE_W-1:0] site_ax2;
		logic [SITE_W-1:0] site_ax1;
		logic [SITE_W-1:0] site_ax0;
	} site_beat_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] phase_im;
		logic signed [OUT_W-1:0] phase_re;
	} phase_beat_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// site_ax0, site_ax1, site_ax2, site_ax3, mom_first, mom_second, mom_third
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// phase_re, phase_im
	logic [OUT_DATA_W-1:0] m_tdata;

	site_beat_t  site_queue[$];
	phase_beat_t phase_expect_q[$];
	int          quarter_lut[QSIZE+1];

	logic [1:0] cur_prop_axis = 2'd3;
	logic       cur_degen = 1'b0;
	int         cur_origin[NUM_AXES] = '{0, 0, 0, 0};

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int cycle_count = 0;

	lattice_momentum_phase_factor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	// Q15 sine of a quarter-turn fraction r / QSIZE, series evaluated in Q30
	function automatic int sine_q15(int unsigned r);
		longint unsigned theta;
		longint unsigned t2;
		longint unsigned term;
		longint          acc;
		longint          q;
		int              k;
		theta = (HALF_PI_Q30 * longint'(r)) >> (PB - 2);
		t2    = (theta * theta) >> 30;
		term  = theta;
		acc   = longint'(theta);
		for (k = 1; k <= 7; k++) begin
			term = ((term * t2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			return 0;
		end
		q = (acc + 16384) >>> 15;
		if (q > 32767) begin
			q = 32767;
		end
		return int'(q);
	endfunction

	function automatic int sin_of_turn(logic [31:0] p);
		int unsigned quad;
		int unsigned r;
		quad = (p >> (PB - 2)) & 3;
		r    = p & (QSIZE - 1);
		case (quad)
			0: return quarter_lut[r];
			1: return quarter_lut[QSIZE - r];
			2: return -quarter_lut[r];
			default: return -quarter_lut[QSIZE - r];
		endcase
	endfunction

	function automatic int cos_of_turn(logic [31:0] p);
		return sin_of_turn(p + QSIZE);
	endfunction

	function automatic int ext_log2(int a);
		case (a)
			0: return LOG2_EXT_AX0_DEF;
			1: return LOG2_EXT_AX1_DEF;
			2: return LOG2_EXT_AX2_DEF;
			default: return LOG2_EXT_AX3_DEF;
		endcase
	endfunction

	// x * n / L_b as a fraction of a turn, exact modulo 2^32
	function automatic logic [31:0] turn_term(int x, logic [MOM_W-1:0] n, int b);
		logic [31:0] xu;
		logic [31:0] prod;
		xu   = x;
		prod = xu * {24'd0, n};
		return prod << (PB - ext_log2(b));
	endfunction

	function automatic int third_of(int s);
		longint m;
		longint q;
		m = (s < 0) ? -longint'(s) : longint'(s);
		q = (m * longint'(THIRD_Q16) + 32768) >>> 16;
		if (q > 32767) begin
			q = 32767;
		end
		return (s < 0) ? -int'(q) : int'(q);
	endfunction

	function automatic phase_beat_t phase_of(site_beat_t b);
		int               disp[NUM_AXES];
		int               ax[NUM_MOM];
		logic [MOM_W-1:0] mom[NUM_MOM];
		logic [31:0]      p0;
		logic [31:0]      p1;
		logic [31:0]      p2;
		int               re;
		int               im;
		phase_beat_t      res;
		disp[0] = int'(b.site_ax0) + cur_origin[0];
		disp[1] = int'(b.site_ax1) + cur_origin[1];
		disp[2] = int'(b.site_ax2) + cur_origin[2];
		disp[3] = int'(b.site_ax3) + cur_origin[3];
		mom[0] = b.mom_first;
		mom[1] = b.mom_second;
		mom[2] = b.mom_third;
		for (int a = 0; a < NUM_MOM; a++) begin
			ax[a] = (int'(cur_prop_axis) + a + 1) & 3;
		end
		p0 = turn_term(disp[ax[0]], mom[0], ax[0]) + turn_term(disp[ax[1]], mom[1], ax[1])
			+ turn_term(disp[ax[2]], mom[2], ax[2]);
		if (cur_degen) begin
			p1 = turn_term(disp[ax[0]], mom[1], ax[1]) + turn_term(disp[ax[1]], mom[2], ax[2])
				+ turn_term(disp[ax[2]], mom[0], ax[0]);
			p2 = turn_term(disp[ax[0]], mom[2], ax[2]) + turn_term(disp[ax[1]], mom[0], ax[0])
				+ turn_term(disp[ax[2]], mom[1], ax[1]);
			re = third_of(cos_of_turn(p0) + cos_of_turn(p1) + cos_of_turn(p2));
			im = third_of(-(sin_of_turn(p0) + sin_of_turn(p1) + sin_of_turn(p2)));
		end else begin
			re = cos_of_turn(p0);
			im = -sin_of_turn(p0);
		end
		res.phase_re = 16'(re);
		res.phase_im = 16'(im);
		return res;
	endfunction

	function automatic site_beat_t make_beat(int s0, int s1, int s2, int s3,
			int n1, int n2, int n3);
		site_beat_t b;
		b.site_ax0   = 8'(s0);
		b.site_ax1   = 8'(s1);
		b.site_ax2   = 8'(s2);
		b.site_ax3   = 8'(s3);
		b.mom_first  = 8'(n1);
		b.mom_second = 8'(n2);
		b.mom_third  = 8'(n3);
		return b;
	endfunction

	// mostly full-range content, some low momenta as a real sweep would use
	function automatic site_beat_t rand_beat();
		site_beat_t  b;
		int unsigned pick;
		b    = site_beat_t'(IN_DATA_W'({$urandom, $urandom}));
		pick = $urandom_range(99);
		if (pick < 25) begin
			b.mom_first  = 8'($urandom_range(3));
			b.mom_second = 8'($urandom_range(3));
			b.mom_third  = 8'($urandom_range(3));
		end else if (pick < 32) begin
			b.mom_first  = '0;
			b.mom_second = '0;
			b.mom_third  = '0;
		end
		return b;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_PROP_AXIS:  cur_prop_axis = val[1:0];
			REG_DEGEN_MODE: cur_degen = val[0];
			REG_ORIGIN_AX0: cur_origin[0] = int'($signed(val));
			REG_ORIGIN_AX1: cur_origin[1] = int'($signed(val));
			REG_ORIGIN_AX2: cur_origin[2] = int'($signed(val));
			REG_ORIGIN_AX3: cur_origin[3] = int'($signed(val));
			default: ;
		endcase
	endtask

	task automatic program_block(input logic [1:0] axis, input logic degen,
			input int o0, input int o1, input int o2, input int o3);
		write_reg(REG_PROP_AXIS, {7'($urandom), axis});
		write_reg(REG_DEGEN_MODE, {8'($urandom), degen});
		write_reg(REG_ORIGIN_AX0, 9'(o0));
		write_reg(REG_ORIGIN_AX1, 9'(o1));
		write_reg(REG_ORIGIN_AX2, 9'(o2));
		write_reg(REG_ORIGIN_AX3, 9'(o3));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (site_queue.size() != 0 || s_tvalid || phase_expect_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) begin
				phase_expect_q.push_back(phase_of(site_beat_t'(s_tdata)));
			end
			if (site_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata  <= site_queue.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_mon
		phase_beat_t want;
		phase_beat_t got;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = phase_beat_t'(m_tdata);
				if (phase_expect_q.size() == 0) begin
					$error("result beat with no expectation pending: %h", m_tdata);
					fail_count++;
				end else begin
					want = phase_expect_q.pop_front();
					if (got.phase_re !== want.phase_re) begin
						$error("phase_re mismatch: expected %0d, actual %0d",
							want.phase_re, got.phase_re);
						fail_count++;
					end
					if (got.phase_im !== want.phase_im) begin
						$error("phase_im mismatch: expected %0d, actual %0d",
							want.phase_im, got.phase_im);
						fail_count++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int k;
		int mode;
		int o[NUM_AXES];
		for (k = 0; k <= QSIZE; k++) begin
			quarter_lut[k] = sine_q15(k);
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// unmapped indexes, then check reset values still hold
		write_reg(CFG_IDX_SPARE_A, 9'h1FF);
		write_reg(CFG_IDX_SPARE_B, 9'h155);
		@(posedge clk);
		cfg_we <= 1'b0;

		site_queue.push_back(make_beat(0, 0, 0, 0, 0, 0, 0));
		site_queue.push_back(make_beat(255, 255, 255, 255, 255, 255, 255));
		site_queue.push_back(make_beat(255, 255, 255, 255, 0, 0, 0));
		site_queue.push_back(make_beat(1, 0, 0, 0, 1, 0, 0));
		site_queue.push_back(make_beat(4, 0, 0, 0, 1, 0, 0));
		site_queue.push_back(make_beat(8, 0, 0, 0, 1, 0, 0));
		site_queue.push_back(make_beat(12, 0, 0, 0, 1, 0, 0));
		site_queue.push_back(make_beat(0, 0, 0, 255, 0, 0, 0));
		site_queue.push_back(make_beat(8'hAA, 8'h55, 8'hAA, 8'h55, 8'h55, 8'hAA, 8'h55));
		site_queue.push_back(make_beat(8'h55, 8'hAA, 8'h55, 8'hAA, 8'hAA, 8'h55, 8'hAA));
		site_queue.push_back(make_beat(3, 5, 7, 9, 2, 3, 4));
		drain();

		// degenerate average at extreme origins; equal terms saturate after one third
		program_block(2'd0, 1'b1, -256, 255, -256, 255);
		site_queue.push_back(make_beat(0, 0, 0, 0, 0, 0, 0));
		site_queue.push_back(make_beat(255, 255, 255, 255, 255, 255, 255));
		site_queue.push_back(make_beat(0, 0, 0, 0, 1, 0, 0));
		site_queue.push_back(make_beat(8'h55, 8'hAA, 8'h55, 8'hAA, 1, 2, 3));
		site_queue.push_back(make_beat(8'hAA, 8'h55, 8'hAA, 8'h55, 255, 0, 128));
		site_queue.push_back(make_beat(16, 16, 16, 32, 4, 4, 4));
		drain();

		for (k = 0; k < NUM_PHASES; k++) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				if (k == 1) begin
					o[a] = -256;
				end else if (k == 6) begin
					o[a] = 255;
				end else begin
					o[a] = int'($urandom_range(511)) - 256;
				end
			end
			program_block(2'(k % 4), 1'(k / 4), o[0], o[1], o[2], o[3]);
			mode = (k + k / 4) % 4;
			sender_idle_pct = (mode == 1) ? 47 : (mode == 3) ? 35 : 0;
			recv_stall_pct  = (mode == 2) ? 47 : (mode == 3) ? 35 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				site_queue.push_back(rand_beat());
			end
			drain();
		end

		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		repeat (8) @(posedge clk);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
